// ===== src/scvdw_pkg.sv =====
// Shared types, constants and saturating helpers for the soft-core vdW pair pipeline.
// Used by the multiplier, the divider and the top level. No dependencies.
package scvdw_pkg;

    typedef logic signed [63:0] t_s64;

    localparam t_s64 S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam t_s64 S64_MIN = 64'sh8000_0000_0000_0000;

    // Latencies of the shared arithmetic units, in register stages.
    localparam int MUL_LAT = 3;
    localparam int QUO_BITS = 63;
    localparam int DIV_LAT = QUO_BITS + 2;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_DIST_SQ = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_SQ = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_SCALE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_COEFF = 2'd3;

    function automatic logic [63:0] f_mag(input t_s64 a);
        logic [63:0] u;
        u = a;
        return u[63] ? (~u + 64'd1) : u;
    endfunction

    function automatic t_s64 f_sat_add(input t_s64 a, input t_s64 b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? S64_MIN : S64_MAX;
        end
        return s[63:0];
    endfunction

    function automatic t_s64 f_sat_sub(input t_s64 a, input t_s64 b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? S64_MIN : S64_MAX;
        end
        return s[63:0];
    endfunction

    // Product by a small integer constant, saturated.
    function automatic t_s64 f_kmul(input t_s64 a, input logic [3:0] k);
        logic [67:0] p;
        p = {4'b0, f_mag(a)} * {64'b0, k};
        if (!a[63]) begin
            return (p[67:63] != 5'd0) ? S64_MAX : p[63:0];
        end
        return (p[67:63] != 5'd0) ? S64_MIN : (64'd0 - p[63:0]);
    endfunction

endpackage

// ===== src/scvdw_if.sv =====
// Channel interfaces of the soft-core vdW pair pipeline: pair input, result output
// and configuration write. Depend on nothing.
interface scvdw_pair_if;
    logic        valid;
    logic        ready;
    logic [63:0] coeff_a;
    logic [63:0] coeff_b;
    logic [62:0] dist_sq;
    logic [62:0] soft_shift;
    logic [32:0] lambda_scale;
    modport source(output valid, coeff_a, coeff_b, dist_sq, soft_shift, lambda_scale,
                   input ready);
    modport sink(input valid, coeff_a, coeff_b, dist_sq, soft_shift, lambda_scale,
                 output ready);
endinterface

interface scvdw_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] energy;
    logic [63:0] force_factor;
    logic [63:0] dudl;
    modport source(output valid, energy, force_factor, dudl, input ready);
    modport sink(input valid, energy, force_factor, dudl, output ready);
endinterface

interface scvdw_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [62:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== src/scvdw_delay.sv =====
// Enabled shift line that carries a value alongside the arithmetic units.
// No dependencies.
module scvdw_delay #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);
    logic [WIDTH-1:0] r_sr [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr[0] <= i_d;
            for (int i = 1; i < DEPTH; i++) begin
                r_sr[i] <= r_sr[i-1];
            end
        end
    end

    assign o_q = r_sr[DEPTH-1];
endmodule

// ===== src/scvdw_fxmul.sv =====
// Three-stage signed fixed-point multiplier with truncation and saturation.
// Depends on scvdw_pkg.
module scvdw_fxmul #(
    parameter int FRAC_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  scvdw_pkg::t_s64    i_a,
    input  scvdw_pkg::t_s64    i_b,
    output scvdw_pkg::t_s64    o_p
);
    import scvdw_pkg::*;

    logic [63:0]  w_ma, w_mb;
    logic [63:0]  r_ll, r_lh, r_hl, r_hh;
    logic         r_neg1, r_neg2;
    logic [127:0] r_prod;
    logic [127:0] w_sh;
    t_s64         r_p;

    assign w_ma = f_mag(i_a);
    assign w_mb = f_mag(i_b);

    // Four 32 x 32 partial products, summed in the next stage.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg1 <= i_a[63] ^ i_b[63];
            r_ll   <= {32'b0, w_ma[31:0]} * {32'b0, w_mb[31:0]};
            r_lh   <= {32'b0, w_ma[31:0]} * {32'b0, w_mb[63:32]};
            r_hl   <= {32'b0, w_ma[63:32]} * {32'b0, w_mb[31:0]};
            r_hh   <= {32'b0, w_ma[63:32]} * {32'b0, w_mb[63:32]};
            r_neg2 <= r_neg1;
            r_prod <= {r_hh, r_ll} + {32'b0, r_lh, 32'b0} + {32'b0, r_hl, 32'b0};
        end
    end

    assign w_sh = r_prod >> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!r_neg2) begin
                r_p <= (w_sh[127:63] != '0) ? S64_MAX : w_sh[63:0];
            end else begin
                r_p <= (w_sh[127:63] != '0) ? S64_MIN : (64'd0 - w_sh[63:0]);
            end
        end
    end

    assign o_p = r_p;
endmodule

// ===== src/scvdw_div.sv =====
// Pipelined fixed-point divider, one quotient bit per stage, saturating.
// Divisor is positive. Depends on scvdw_pkg.
module scvdw_div #(
    parameter int FRAC_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  scvdw_pkg::t_s64    i_num,
    input  logic [62:0]        i_den,
    output scvdw_pkg::t_s64    o_quo
);
    import scvdw_pkg::*;

    logic [62:0] r_rem [0:QUO_BITS];
    logic [62:0] r_quo [0:QUO_BITS];
    logic [63:0] r_mag [0:QUO_BITS];
    logic [62:0] r_den [0:QUO_BITS];
    logic        r_neg [0:QUO_BITS];
    logic        r_ovf [0:QUO_BITS];
    logic [63:0] w_mag, w_top;
    logic        w_ovf;
    t_s64        r_out;

    // The quotient overflows 63 bits exactly when the scaled dividend from bit 63 up
    // already reaches the divisor; otherwise that part seeds the remainder.
    assign w_mag = f_mag(i_num);
    assign w_top = w_mag >> (63 - FRAC_BITS);
    assign w_ovf = w_top >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_ovf ? '0 : w_top[62:0];
            r_quo[0] <= '0;
            r_mag[0] <= w_mag;
            r_den[0] <= i_den;
            r_neg[0] <= i_num[63];
            r_ovf[0] <= w_ovf;
        end
    end

    for (genvar j = 1; j <= QUO_BITS; j++) begin : g_stage
        localparam int K = QUO_BITS - j;
        logic        w_nb;
        logic [63:0] w_trial, w_diff;
        logic        w_ge;
        if (K >= FRAC_BITS) begin : g_bit
            assign w_nb = r_mag[j-1][K-FRAC_BITS];
        end else begin : g_zero
            assign w_nb = 1'b0;
        end
        assign w_trial = {r_rem[j-1], w_nb};
        assign w_ge    = w_trial >= {1'b0, r_den[j-1]};
        assign w_diff  = w_trial - {1'b0, r_den[j-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= w_ge ? w_diff[62:0] : w_trial[62:0];
                r_quo[j] <= {r_quo[j-1][61:0], w_ge};
                r_mag[j] <= r_mag[j-1];
                r_den[j] <= r_den[j-1];
                r_neg[j] <= r_neg[j-1];
                r_ovf[j] <= r_ovf[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_ovf[QUO_BITS]) begin
                r_out <= r_neg[QUO_BITS] ? S64_MIN : S64_MAX;
            end else if (r_neg[QUO_BITS]) begin
                r_out <= 64'd0 - {1'b0, r_quo[QUO_BITS]};
            end else begin
                r_out <= {1'b0, r_quo[QUO_BITS]};
            end
        end
    end

    assign o_quo = r_out;
endmodule

// ===== src/softcore_vdw_energy_force_dudl.sv =====
// Soft-core Lennard-Jones pair pipeline with switching: energy, force factor, dU/dlambda.
// Depends on scvdw_pkg, scvdw_if, scvdw_delay, scvdw_fxmul and scvdw_div.
//
// Use: pair beats arrive on i_pair (valid/ready); each produces exactly one result
// beat on o_result, in order. Configuration registers (switch distance squared,
// cutoff squared, switch scale, shift coefficient) are written on i_cfg, which
// is ready whenever reset is released; write them only while no pair is in flight.
// Throughput: one pair per cycle, sustained while the receiver takes every result. The
// critical path runs through two of the three pipelined dividers (65 stages each, one
// quotient bit per stage between input and output registers) and chains of three-stage
// multipliers: reciprocal -> r^-6 -> r^-12 -> terms -> quotient -> force and dU/dlambda.
// All pipeline stages advance together. When the receiver stalls, the result in
// the output register moves into a skid register and the pipeline then holds
// until the skid beat is taken; i_pair.ready is that skid register empty while
// reset is released.
// Reset (synchronous, active low) clears all valid bits, including the skid register's,
// and the configuration registers to zero; the data registers are not reset.
module softcore_vdw_energy_force_dudl #(
    parameter int FRAC_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    scvdw_pair_if.sink            i_pair,
    scvdw_result_if.source        o_result,
    scvdw_cfg_if.sink             i_cfg
);
    import scvdw_pkg::*;

    localparam t_s64 FX_ONE = t_s64'(64'd1 << FRAC_BITS);

    localparam int T_R21   = 1;
    localparam int T_G     = T_R21 + 1;
    localparam int T_SD    = T_R21 + MUL_LAT;
    localparam int T_SDD   = T_SD + MUL_LAT;
    localparam int T_SWR   = T_SDD + MUL_LAT;
    localparam int T_SEL   = T_SWR + 1;
    localparam int T_LSW   = T_SEL + MUL_LAT;
    localparam int T_INV2  = T_R21 + DIV_LAT;
    localparam int T_P2    = T_INV2 + MUL_LAT;
    localparam int T_INV6  = T_P2 + MUL_LAT;
    localparam int T_INV12 = T_INV6 + MUL_LAT;
    localparam int T_TA    = T_INV12 + MUL_LAT;
    localparam int T_E     = T_TA + 1;
    localparam int T_NUM   = T_E + 1;
    localparam int T_EN    = T_E + MUL_LAT;
    localparam int T_T     = T_NUM + DIV_LAT;
    localparam int T_P     = T_T + MUL_LAT;
    localparam int T_SUM   = T_P + 1;
    localparam int T_FIN   = T_SUM + MUL_LAT;
    localparam int T_OUT   = T_FIN + 1;

    // Configuration
    logic [62:0] r_cfg_sw0, r_cfg_cut, r_cfg_scl, r_cfg_shc;

    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_sw0 <= '0;
            r_cfg_cut <= '0;
            r_cfg_scl <= '0;
            r_cfg_shc <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_SWITCH_DIST_SQ: r_cfg_sw0 <= i_cfg.data;
                CFG_CUTOFF_SQ:      r_cfg_cut <= i_cfg.data;
                CFG_SWITCH_SCALE:   r_cfg_scl <= i_cfg.data;
                CFG_SHIFT_COEFF:    r_cfg_shc <= i_cfg.data;
                default: ;
            endcase
        end
    end

    t_s64 w_sw0, w_cut, w_scl, w_shc;
    assign w_sw0 = {1'b0, r_cfg_sw0};
    assign w_cut = {1'b0, r_cfg_cut};
    assign w_scl = {1'b0, r_cfg_scl};
    assign w_shc = {1'b0, r_cfg_shc};

    // Pipeline control and output skid register
    logic             w_en;
    logic [T_OUT:0]   r_vld;
    logic             r_sk_v;
    t_s64             r_sk_energy, r_sk_force, r_sk_dudl;
    t_s64             r_o_energy, r_o_force, r_o_dudl;

    assign w_en         = !r_sk_v;
    assign i_pair.ready = w_en && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_sk_v <= 1'b0;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[T_OUT-1:0], i_pair.valid};
            end
            if (w_en && r_vld[T_OUT] && !o_result.ready) begin
                r_sk_v <= 1'b1;
            end else if (r_sk_v && o_result.ready) begin
                r_sk_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_vld[T_OUT] && !o_result.ready) begin
            r_sk_energy <= r_o_energy;
            r_sk_force  <= r_o_force;
            r_sk_dudl   <= r_o_dudl;
        end
    end

    assign o_result.valid        = r_sk_v | r_vld[T_OUT];
    assign o_result.energy       = r_sk_v ? r_sk_energy : r_o_energy;
    assign o_result.force_factor = r_sk_v ? r_sk_force : r_o_force;
    assign o_result.dudl         = r_sk_v ? r_sk_dudl : r_o_dudl;

    // Input stage and shifted distance
    t_s64        r_a, r_b;
    logic [62:0] r_r2, r_sh;
    logic [32:0] r_lam;
    logic [63:0] w_sum;
    logic [62:0] r_r21;
    logic        r_zero;
    t_s64        w_r2;
    t_s64        r_d, r_r2x2, r_g1, r_dr, r_sc12, r_g;
    logic        r_swon;

    assign w_sum = {1'b0, r_r2} + {1'b0, r_sh};
    assign w_r2  = {1'b0, r_r2};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a    <= i_pair.coeff_a;
            r_b    <= i_pair.coeff_b;
            r_r2   <= i_pair.dist_sq;
            r_sh   <= i_pair.soft_shift;
            r_lam  <= i_pair.lambda_scale;
            r_r21  <= w_sum[63] ? S64_MAX[62:0] : w_sum[62:0];
            r_zero <= (w_sum == 64'd0);
            r_d    <= f_sat_sub(w_cut, w_r2);
            r_r2x2 <= f_kmul(w_r2, 4'd2);
            r_g1   <= f_sat_sub(w_cut, f_kmul(w_sw0, 4'd3));
            r_dr   <= f_sat_sub(w_r2, w_sw0);
            r_sc12 <= f_kmul(w_scl, 4'd12);
            r_swon <= r_r2 > r_cfg_sw0;
            r_g    <= f_sat_add(r_g1, r_r2x2);
        end
    end

    // Switching polynomial
    t_s64 w_d_sd, w_g_sdd, w_dr_sd, w_sd, w_sdd, w_swr, w_s12d, w_sw2r, w_sw2r_d;
    logic w_swon_d;
    t_s64 r_sw, r_sw2;

    scvdw_delay #(.WIDTH(64), .DEPTH(T_SD - T_R21)) u_dly_d (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_d), .o_q(w_d_sd));
    scvdw_delay #(.WIDTH(64), .DEPTH(T_SDD - T_G)) u_dly_g (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_g), .o_q(w_g_sdd));
    scvdw_delay #(.WIDTH(64), .DEPTH(T_SD - T_R21)) u_dly_dr (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_dr), .o_q(w_dr_sd));
    scvdw_delay #(.WIDTH(1), .DEPTH(T_SWR - T_R21)) u_dly_swon (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_swon), .o_q(w_swon_d));

    scvdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_sd (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_scl), .i_b(r_d), .o_p(w_sd));
    scvdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_sdd (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_sd), .i_b(w_d_sd), .o_p(w_sdd));
    scvdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_swr (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_sdd), .i_b(w_g_sdd), .o_p(w_swr));
    scvdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_s12d (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_sc12), .i_b(r_d), .o_p(w_s12d));
    scvdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_sw2 (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_s12d), .i_b(w_dr_sd), .o_p(w_sw2r));
    scvdw_delay #(.WIDTH(64), .DEPTH(T_SWR - T_SDD)) u_dly_sw2r (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_sw2r), .o_q(w_sw2r_d));

    // Inside the switch distance the taper is flat: one for energy, zero slope.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sw  <= w_swon_d ? w_swr : FX_ONE;
            r_sw2 <= w_swon_d ? w_sw2r_d : '0;
        end
    end

    // Lambda products
    logic [32:0] w_lam_sel, w_lam_sum;
    t_s64        w_lam_s, w_lam_f, w_lsw, w_lshc;

    scvdw_delay #(.WIDTH(33), .DEPTH(T_SEL)) u_dly_lam1 (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_lam), .o_q(w_lam_sel));
    scvdw_delay #(.WIDTH(33), .DEPTH(T_SUM - T_SEL)) u_dly_lam2 (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_lam_sel), .o_q(w_lam_sum));
    assign w_lam_s = {31'b0, w_lam_sel};
    assign w_lam_f = {31'b0, w_lam_sum};

    scvdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_lsw (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_lam_s), .i_b(r_sw), .o_p(w_lsw));
    scvdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_lshc (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_lam_s), .i_b(w_shc), .o_p(w_lshc));

    // Inverse powers of the shifted distance and the two terms
    t_s64 w_inv2, w_inv2_d, w_p2, w_inv6, w_inv12, w_b_d, w_tb, w_tb_d, w_a_d, w_ta;
    t_s64 r_e, r_ta, r_tb, r_num1, r_num2;

    scvdw_div #(.FRAC_BITS(FRAC_BITS)) u_div_inv (
        .i_clk(i_clk), .i_en(w_en), .i_num(FX_ONE), .i_den(r_r21), .o_quo(w_inv2));
    scvdw_delay #(.WIDTH(64), .DEPTH(T_P2 - T_INV2)) u_dly_inv2 (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_inv2), .o_q(w_inv2_d));
    scvdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_p2 (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_inv2), .i_b(w_inv2), .o_p(w_p2));
    scvdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_inv6 (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_p2), .i_b(w_inv2_d), .o_p(w_inv6));
    scvdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_inv12 (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_inv6), .i_b(w_inv6), .o_p(w_inv12));
    scvdw_delay #(.WIDTH(64), .DEPTH(T_INV6)) u_dly_b (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_b), .o_q(w_b_d));
    scvdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_tb (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_b_d), .i_b(w_inv6), .o_p(w_tb));
    scvdw_delay #(.WIDTH(64), .DEPTH(T_TA - T_INV12)) u_dly_tb (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_tb), .o_q(w_tb_d));
    scvdw_delay #(.WIDTH(64), .DEPTH(T_INV12)) u_dly_a (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_a), .o_q(w_a_d));
    scvdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_ta (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_a_d), .i_b(w_inv12), .o_p(w_ta));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e    <= f_sat_sub(w_ta, w_tb_d);
            r_ta   <= w_ta;
            r_tb   <= w_tb_d;
            r_num1 <= f_sat_add(f_kmul(r_e, 4'd12), f_kmul(r_tb, 4'd6));
            r_num2 <= f_sat_sub(f_kmul(r_ta, 4'd6), f_kmul(r_tb, 4'd3));
        end
    end

    // Quotients by the shifted distance
    logic [62:0] w_r21_d;
    t_s64        w_t1, w_t2;

    scvdw_delay #(.WIDTH(63), .DEPTH(T_NUM - T_R21)) u_dly_r21 (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_r21), .o_q(w_r21_d));
    scvdw_div #(.FRAC_BITS(FRAC_BITS)) u_div_force (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_num1), .i_den(w_r21_d), .o_quo(w_t1));
    scvdw_div #(.FRAC_BITS(FRAC_BITS)) u_div_dudl (
        .i_clk(i_clk), .i_en(w_en), .i_num(r_num2), .i_den(w_r21_d), .o_quo(w_t2));

    // Energy
    t_s64 w_lsw_d, w_en_raw, w_en_fin;

    scvdw_delay #(.WIDTH(64), .DEPTH(T_E - T_LSW)) u_dly_lsw (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_lsw), .o_q(w_lsw_d));
    scvdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_en (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_e), .i_b(w_lsw_d), .o_p(w_en_raw));
    scvdw_delay #(.WIDTH(64), .DEPTH(T_FIN - T_EN)) u_dly_en (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_en_raw), .o_q(w_en_fin));

    // Force factor and dU/dlambda
    t_s64 w_sw2_e, w_esw2, w_esw2_d, w_sw_t, w_sw_sum, w_t1sw, w_lshc_t, w_lt2, w_e_p;
    t_s64 r_fsum, r_dsum, w_fo, w_du;

    scvdw_delay #(.WIDTH(64), .DEPTH(T_E - T_SEL)) u_dly_sw2 (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_sw2), .o_q(w_sw2_e));
    scvdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_esw2 (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_e), .i_b(w_sw2_e), .o_p(w_esw2));
    scvdw_delay #(.WIDTH(64), .DEPTH(T_P - T_EN)) u_dly_esw2 (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_esw2), .o_q(w_esw2_d));
    scvdw_delay #(.WIDTH(64), .DEPTH(T_T - T_SEL)) u_dly_sw1 (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_sw), .o_q(w_sw_t));
    scvdw_delay #(.WIDTH(64), .DEPTH(T_SUM - T_T)) u_dly_sw2b (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_sw_t), .o_q(w_sw_sum));
    scvdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_t1sw (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_t1), .i_b(w_sw_t), .o_p(w_t1sw));
    scvdw_delay #(.WIDTH(64), .DEPTH(T_T - T_LSW)) u_dly_lshc (
        .i_clk(i_clk), .i_en(w_en), .i_d(w_lshc), .o_q(w_lshc_t));
    scvdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_lt2 (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_lshc_t), .i_b(w_t2), .o_p(w_lt2));
    scvdw_delay #(.WIDTH(64), .DEPTH(T_P - T_E)) u_dly_e (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_e), .o_q(w_e_p));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fsum <= f_sat_add(w_t1sw, w_esw2_d);
            r_dsum <= f_sat_add(w_lt2, w_e_p);
        end
    end

    scvdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_fo (
        .i_clk(i_clk), .i_en(w_en), .i_a(w_lam_f), .i_b(r_fsum), .o_p(w_fo));
    scvdw_fxmul #(.FRAC_BITS(FRAC_BITS)) u_mul_du (
        .i_clk(i_clk), .i_en(w_en), .i_a(r_dsum), .i_b(w_sw_sum), .o_p(w_du));

    // Output register; a zero shifted distance forces all fields to the maximum.
    logic w_zero_d;

    scvdw_delay #(.WIDTH(1), .DEPTH(T_FIN - T_R21)) u_dly_zero (
        .i_clk(i_clk), .i_en(w_en), .i_d(r_zero), .o_q(w_zero_d));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_energy <= w_zero_d ? S64_MAX : w_en_fin;
            r_o_force  <= w_zero_d ? S64_MAX : w_fo;
            r_o_dudl   <= w_zero_d ? S64_MAX : w_du;
        end
    end
endmodule

// ===== tb/sv/scvdw_tb_if.sv =====
`timescale 1ns / 1ps
// Channel interface instances are taken from the RTL interface file; this file holds
// the testbench's own beat types for pairs and results. Depends on nothing.
package scvdw_tb_types;

    typedef struct packed {
        logic [63:0] coeff_a;
        logic [63:0] coeff_b;
        logic [62:0] dist_sq;
        logic [62:0] soft_shift;
        logic [32:0] lambda_scale;
    } t_pair;

    typedef struct packed {
        logic [63:0] energy;
        logic [63:0] force_factor;
        logic [63:0] dudl;
    } t_pair_result;

endpackage

// ===== tb/sv/tb_softcore_vdw_energy_force_dudl.sv =====
`timescale 1ns / 1ps
// Testbench for the soft-core vdW pair pipeline: directed and random pairs under random
// stalls, checked against a fixed-point predictor. Depends on the RTL and scvdw_tb_types.
module tb_softcore_vdw_energy_force_dudl;
    import scvdw_pkg::*;
    import scvdw_tb_types::*;

    localparam int FRAC = 32;
    localparam int LATENCY = 154;
    localparam longint LIMIT = 400000;
    localparam logic signed [63:0] FX_ONE = 64'sd1 <<< FRAC;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    scvdw_pair_if   pair_ch();
    scvdw_result_if res_ch();
    scvdw_cfg_if    cfg_ch();

    softcore_vdw_energy_force_dudl dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_pair(pair_ch.sink), .o_result(res_ch.source), .i_cfg(cfg_ch.sink)
    );

    logic [62:0] r_switch_dist_sq = '0, r_cutoff_sq = '0;
    logic [62:0] r_switch_scale = '0, r_shift_coeff = '0;
    t_pair_result expected_results[$];
    int errors = 0;
    longint cycles = 0;
    bit rx_calm = 1'b0;

    // ---- saturating fixed point predictor ----
    function automatic logic signed [63:0] clamp128(logic signed [127:0] v);
        if (v > 128'sh7FFF_FFFF_FFFF_FFFF) return S64_MAX;
        if (v < -128'sh8000_0000_0000_0000) return S64_MIN;
        return v[63:0];
    endfunction

    function automatic logic signed [127:0] wide(logic signed [63:0] a);
        return {{64{a[63]}}, a};
    endfunction

    // Product truncated toward zero on magnitudes.
    function automatic logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] b);
        logic [127:0] m;
        logic [127:0] p;
        bit neg;
        neg = a[63] != b[63];
        m = {64'd0, f_mag(a)} * {64'd0, f_mag(b)};
        p = m >> FRAC;
        if (!neg) return (p > 128'h7FFF_FFFF_FFFF_FFFF) ? S64_MAX : p[63:0];
        return (p >= 128'h8000_0000_0000_0000) ? S64_MIN : -$signed(p[63:0]);
    endfunction

    function automatic logic signed [63:0] qdiv(logic signed [63:0] a, logic signed [63:0] b);
        logic [127:0] n;
        logic [127:0] q;
        bit neg;
        neg = a[63] != b[63];
        if (b == 0) return (a == 0) ? 64'sd0 : (a[63] ? S64_MIN : S64_MAX);
        n = {64'd0, f_mag(a)} << FRAC;
        q = n / {64'd0, f_mag(b)};
        if (!neg) return (q > 128'h7FFF_FFFF_FFFF_FFFF) ? S64_MAX : q[63:0];
        return (q >= 128'h8000_0000_0000_0000) ? S64_MIN : -$signed(q[63:0]);
    endfunction

    function automatic logic signed [63:0] sadd(logic signed [63:0] a, logic signed [63:0] b);
        return clamp128(wide(a) + wide(b));
    endfunction

    function automatic logic signed [63:0] ssub(logic signed [63:0] a, logic signed [63:0] b);
        return clamp128(wide(a) - wide(b));
    endfunction

    function automatic logic signed [63:0] kmul(logic signed [63:0] a, int k);
        return clamp128(wide(a) * k);
    endfunction

    function automatic t_pair_result predict_pair(t_pair p);
        t_pair_result r;
        logic [63:0] sum;
        logic signed [63:0] r21, r2, sw0, cut, scl, shc, lam, a, b;
        logic signed [63:0] inv2, inv6, inv12, ta, tb, e, sw, sw2, d, g, t, fo, du, en;
        a = p.coeff_a; b = p.coeff_b;
        r2 = {1'b0, p.dist_sq};
        lam = {31'd0, p.lambda_scale};
        sw0 = {1'b0, r_switch_dist_sq}; cut = {1'b0, r_cutoff_sq};
        scl = {1'b0, r_switch_scale}; shc = {1'b0, r_shift_coeff};
        sum = {1'b0, p.dist_sq} + {1'b0, p.soft_shift};
        if (sum == 0) begin
            r.energy = S64_MAX; r.force_factor = S64_MAX; r.dudl = S64_MAX;
            return r;
        end
        r21 = sum[63] ? S64_MAX : sum;
        inv2 = qdiv(FX_ONE, r21);
        inv6 = qmul(qmul(inv2, inv2), inv2);
        inv12 = qmul(inv6, inv6);
        ta = qmul(a, inv12);
        tb = qmul(b, inv6);
        e = ssub(ta, tb);
        if (p.dist_sq > r_switch_dist_sq) begin
            d = ssub(cut, r2);
            g = sadd(ssub(cut, kmul(sw0, 3)), kmul(r2, 2));
            sw = qmul(qmul(qmul(scl, d), d), g);
            sw2 = qmul(qmul(kmul(scl, 12), d), ssub(r2, sw0));
        end else begin
            sw = FX_ONE;
            sw2 = 0;
        end
        t = qdiv(sadd(kmul(e, 12), kmul(tb, 6)), r21);
        fo = qmul(lam, sadd(qmul(t, sw), qmul(e, sw2)));
        t = qdiv(ssub(kmul(ta, 6), kmul(tb, 3)), r21);
        du = qmul(sadd(qmul(qmul(lam, shc), t), e), sw);
        en = qmul(e, qmul(lam, sw));
        r.energy = en; r.force_factor = fo; r.dudl = du;
        return r;
    endfunction

    // ---- result side: random stalls, then compare with the oldest expectation ----
    int rx_hold = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no pair outstanding");
                    errors++;
                end else begin
                    t_pair_result x;
                    x = expected_results.pop_front();
                    if (res_ch.energy !== x.energy) begin
                        $error("energy expected %h actual %h", x.energy, res_ch.energy);
                        errors++;
                    end
                    if (res_ch.force_factor !== x.force_factor) begin
                        $error("force_factor expected %h actual %h",
                               x.force_factor, res_ch.force_factor);
                        errors++;
                    end
                    if (res_ch.dudl !== x.dudl) begin
                        $error("dudl expected %h actual %h", x.dudl, res_ch.dudl);
                        errors++;
                    end
                end
            end
            if (rx_hold > 0) begin
                rx_hold <= rx_hold - 1;
                res_ch.ready <= 1'b0;
            end else if (!rx_calm && $urandom_range(0, 9) == 0) begin
                rx_hold <= $urandom_range(1, 7) - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // After the write beat the task drops valid, lets the channel go idle and then updates its copy.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [62:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_SWITCH_DIST_SQ: r_switch_dist_sq = val;
            CFG_CUTOFF_SQ:      r_cutoff_sq = val;
            CFG_SWITCH_SCALE:   r_switch_scale = val;
            CFG_SHIFT_COEFF:    r_shift_coeff = val;
            default: ;
        endcase
    endtask

    task automatic send_pair(t_pair p, bit gaps);
        int n;
        if (gaps && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 7);
            pair_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        pair_ch.valid <= 1'b1;
        pair_ch.coeff_a <= p.coeff_a;
        pair_ch.coeff_b <= p.coeff_b;
        pair_ch.dist_sq <= p.dist_sq;
        pair_ch.soft_shift <= p.soft_shift;
        pair_ch.lambda_scale <= p.lambda_scale;
        do @(posedge i_clk); while (!pair_ch.ready);
        expected_results.push_back(predict_pair(p));
    endtask

    task automatic drain();
        pair_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Distances near 1.0 keep the r^-12 terms in range; some are fully random.
    function automatic t_pair random_pair();
        t_pair p;
        p.coeff_a = ($urandom_range(0, 3) == 0) ? rand64() : {{24{1'b0}}, 40'(rand64())};
        p.coeff_b = ($urandom_range(0, 3) == 0) ? rand64() : {{24{1'b0}}, 40'(rand64())};
        if ($urandom_range(0, 1)) p.coeff_b = -$signed(p.coeff_b);
        p.dist_sq = ($urandom_range(0, 4) == 0)
                    ? 63'(rand64())
                    : 63'($urandom_range(0, 15)) << 30 | 63'($urandom);
        p.soft_shift = ($urandom_range(0, 4) == 0) ? 63'(rand64())
                                                   : 63'($urandom_range(0, 3)) << 28;
        p.lambda_scale = ($urandom_range(0, 5) == 0)
                         ? 33'(rand64())
                         : 33'($urandom_range(0, 32'hFFFF_FFFF)) + 33'($urandom_range(0, 1));
        return p;
    endfunction

    // Directed pairs: zero shifted distance, extremes of every field, lambda above 1.0.
    t_pair directed [0:13];
    t_pair_result directed_known [0:13];
    bit directed_has_known [0:13];

    initial begin
        t_pair p;
        pair_ch.valid = 1'b0;
        pair_ch.coeff_a = '0; pair_ch.coeff_b = '0; pair_ch.dist_sq = '0;
        pair_ch.soft_shift = '0; pair_ch.lambda_scale = '0;
        cfg_ch.valid = 1'b0; cfg_ch.index = CFG_SWITCH_DIST_SQ; cfg_ch.data = '0;
        res_ch.ready = 1'b0;
        foreach (directed_has_known[i]) directed_has_known[i] = 1'b0;
        directed[0] = '{64'sd1 <<< 32, 64'sd1 <<< 32, 63'd0, 63'd0, 33'd1 << 32};
        directed_known[0] = '{S64_MAX, S64_MAX, S64_MAX};
        directed_has_known[0] = 1'b1;
        directed[1] = '{S64_MAX, S64_MIN, 63'd0, 63'd0, '1};
        directed_known[1] = '{S64_MAX, S64_MAX, S64_MAX};
        directed_has_known[1] = 1'b1;
        // Unit distance, A = B = 0: everything is zero.
        directed[2] = '{64'd0, 64'd0, 63'd1 << 32, 63'd0, 33'd1 << 32};
        directed_known[2] = '{64'd0, 64'd0, 64'd0};
        directed_has_known[2] = 1'b1;
        directed[3] = '{64'sd1 <<< 32, 64'd0, 63'd1 << 32, 63'd0, 33'd1 << 32};
        directed[4] = '{64'd0, 64'sd1 <<< 32, 63'd1 << 32, 63'd0, 33'd1 << 32};
        directed[5] = '{S64_MAX, S64_MIN, 63'd1, 63'd0, '1};
        directed[6] = '{S64_MIN, S64_MAX, '1, '1, '1};
        directed[7] = '{S64_MAX, S64_MAX, '1, 63'd0, 33'd0};
        directed[8] = '{64'sd3 <<< 32, 64'sd2 <<< 32, 63'd2 << 32, 63'd1 << 31, 33'd1 << 31};
        directed[9] = '{64'sd3 <<< 32, -(64'sd2 <<< 32), 63'd0, 63'd1 << 32, '1};
        directed[10] = '{'1, '1, 63'd1, 63'd1, 33'd1};
        directed[11] = '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                         63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555, 33'h0_AAAA_AAAA};
        directed[12] = '{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                         63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 33'h1_5555_5555};
        directed[13] = '{64'sd7 <<< 32, 64'sd5 <<< 32, 63'd3 << 31, 63'd0, 33'd3 << 31};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Registers at reset are zero: switching is off only when the distance is zero.
        for (int i = 0; i < 14; i++) begin
            t_pair_result want;
            want = predict_pair(directed[i]);
            if (directed_has_known[i] && want !== directed_known[i]) begin
                $error("row %0d: predictor expected %h actual %h", i, directed_known[i], want);
                errors++;
            end
            send_pair(directed[i], 1'b1);
        end
        drain();

        // Phases of settings, the extremes among them, each with random pairs.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_SWITCH_DIST_SQ, 63'd1 << 32);
                    write_reg(CFG_CUTOFF_SQ, 63'd9 << 32);
                    write_reg(CFG_SWITCH_SCALE, 63'd8388608);
                    write_reg(CFG_SHIFT_COEFF, 63'd1 << 31);
                end
                1: begin
                    write_reg(CFG_SWITCH_DIST_SQ, '1);
                    write_reg(CFG_CUTOFF_SQ, '1);
                    write_reg(CFG_SWITCH_SCALE, '1);
                    write_reg(CFG_SHIFT_COEFF, '1);
                end
                2: begin
                    // Cutoff below the switch distance.
                    write_reg(CFG_SWITCH_DIST_SQ, 63'd4 << 32);
                    write_reg(CFG_CUTOFF_SQ, 63'd1 << 32);
                    write_reg(CFG_SWITCH_SCALE, 63'($urandom) << 8);
                    write_reg(CFG_SHIFT_COEFF, 63'($urandom));
                end
                3: begin
                    write_reg(CFG_SWITCH_DIST_SQ, 63'($urandom_range(0, 3)) << 31);
                    write_reg(CFG_CUTOFF_SQ, 63'($urandom_range(4, 30)) << 31);
                    write_reg(CFG_SWITCH_SCALE, 63'(rand64()));
                    write_reg(CFG_SHIFT_COEFF, 63'(rand64()));
                end
                default: begin
                    write_reg(CFG_SWITCH_DIST_SQ, '0);
                    write_reg(CFG_CUTOFF_SQ, '0);
                    write_reg(CFG_SWITCH_SCALE, '0);
                    write_reg(CFG_SHIFT_COEFF, '0);
                end
            endcase
            for (int k = 0; k < 80; k++) begin
                if (phase == 4 && k >= 40) rx_calm = 1'b1;
                p = random_pair();
                send_pair(p, !rx_calm);
            end
            drain();
        end

        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/scvdw_pkg.sv
src/scvdw_if.sv
src/scvdw_delay.sv
src/scvdw_fxmul.sv
src/scvdw_div.sv
src/softcore_vdw_energy_force_dudl.sv
tb/sv/scvdw_tb_if.sv
tb/sv/tb_softcore_vdw_energy_force_dudl.sv
